### design/sice_pkg.sv
package sice_pkg;

  // Sizes of the module chain.
  localparam int MAX_MODULES     = 8;
  localparam int BITS_PER_MODULE = 8;
  localparam int MOD_W           = $clog2(MAX_MODULES);
  localparam int BIT_W           = $clog2(BITS_PER_MODULE);
  localparam int PIN_W           = 6;
  localparam int COUNT_W         = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  // Operation codes of an input item.
  localparam logic [1:0] OP_SAMPLE    = 2'd0;
  localparam logic [1:0] OP_PRIME     = 2'd1;
  localparam logic [1:0] OP_RETRIGGER = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] module_index;
    logic [7:0] sample_byte;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0] input_number;
    logic             is_press;
    logic             last_of_run;
  } out_item_t;

  // Work that the front hands to the back.
  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_PRIME,
    CMD_RETRIGGER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [MOD_W-1:0]           module_index;
    logic [BITS_PER_MODULE-1:0] sample_byte;
    logic [MOD_W-1:0]           last_module;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } back_state_t;

endpackage

### design/sice_front.sv
module sice_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sice_pkg::in_item_t       in_data,
  input  logic [sice_pkg::COUNT_W-1:0] module_count,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output sice_pkg::cmd_t           cmd_data
);
  import sice_pkg::*;

  logic [MOD_W-1:0] last_module;
  logic             index_ok;
  logic             keep;
  cmd_t             push_cmd;

  // Highest module in use, with the count clamped to the chain length.
  always_comb begin
    priority if (module_count == '0) begin
      last_module = '0;
    end else if (module_count > COUNT_W'(MAX_MODULES)) begin
      last_module = MOD_W'(MAX_MODULES - 1);
    end else begin
      last_module = MOD_W'(module_count - COUNT_W'(1));
    end
  end

  assign index_ok = ({1'b0, in_data.module_index} < 4'(MAX_MODULES)) &&
                    (MOD_W'(in_data.module_index) <= last_module);

  // Classify the item; ignored items are taken and dropped here.
  always_comb begin
    push_cmd.module_index = MOD_W'(in_data.module_index);
    push_cmd.sample_byte  = in_data.sample_byte;
    push_cmd.last_module  = last_module;
    push_cmd.kind         = CMD_SAMPLE;
    keep                  = 1'b0;
    unique case (in_data.operation)
      OP_SAMPLE: begin
        push_cmd.kind = CMD_SAMPLE;
        keep          = index_ok;
      end
      OP_PRIME: begin
        push_cmd.kind = CMD_PRIME;
        keep          = index_ok;
      end
      OP_RETRIGGER: begin
        push_cmd.kind = CMD_RETRIGGER;
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  sice_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(in_valid && keep),
    .push_ready(in_ready),
    .push_data (push_cmd),
    .pop_valid (cmd_valid),
    .pop_ready (cmd_ready),
    .pop_data  (cmd_data)
  );

endmodule

### design/sice_queue.sv
module sice_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  sice_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sice_pkg::cmd_t pop_data
);
  import sice_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/sice_back.sv
module sice_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  sice_pkg::cmd_t      cmd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sice_pkg::out_item_t out_data
);
  import sice_pkg::*;

  back_state_t                state_r, state_nxt;
  logic [BITS_PER_MODULE-1:0] levels_r [MAX_MODULES];
  logic [BIT_W-1:0]           bit_r;
  logic [MOD_W-1:0]           mod_r;
  logic                       pass_r;
  logic                       retrig_r;
  logic [MOD_W-1:0]           last_mod_r;
  logic [BITS_PER_MODULE-1:0] diff_r;
  logic [BITS_PER_MODULE-1:0] byte_r;
  logic                       hold_valid_r;
  logic [PIN_W-1:0]           hold_pin_r;
  logic                       hold_press_r;
  logic                       out_valid_r;
  out_item_t                  out_r;

  logic [BITS_PER_MODULE-1:0] cur_levels;
  logic                       hit;
  logic                       hit_press;
  logic                       walk_end;
  logic                       can_push;
  logic                       advance;
  logic                       push;
  logic                       push_last;
  logic                       take;

  // Candidate event at the current walk position.
  always_comb begin
    cur_levels = levels_r[mod_r];
    if (retrig_r) begin
      hit       = pass_r ? ~cur_levels[bit_r] : cur_levels[bit_r];
      hit_press = pass_r;
      walk_end  = pass_r && (mod_r == last_mod_r) && (bit_r == BIT_W'(BITS_PER_MODULE - 1));
    end else begin
      hit       = diff_r[bit_r];
      hit_press = ~byte_r[bit_r];
      walk_end  = (bit_r == BIT_W'(BITS_PER_MODULE - 1));
    end
  end

  assign can_push = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd_data.kind != CMD_PRIME) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (advance && walk_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_r || can_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer. An event waits in the hold register
  // until the next one shows up, so the final one can be flagged.
  always_comb begin
    take      = 1'b0;
    advance   = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        take = cmd_valid;
      end
      ST_WALK: begin
        advance = !(hit && hold_valid_r && !can_push);
        push    = advance && hit && hold_valid_r;
      end
      ST_FLUSH: begin
        push      = hold_valid_r && can_push;
        push_last = 1'b1;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  assign cmd_ready = take;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_MODULES; i++) begin
        levels_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // Stored levels change when a sample or prime is taken.
      if (take && cmd_data.kind != CMD_RETRIGGER) begin
        levels_r[cmd_data.module_index] <= cmd_data.sample_byte;
      end
      // Hold register.
      if (advance && hit) begin
        hold_valid_r <= 1'b1;
      end else if (state_r == ST_FLUSH && push) begin
        hold_valid_r <= 1'b0;
      end
      // Output register.
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk position and payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      retrig_r   <= (cmd_data.kind == CMD_RETRIGGER);
      mod_r      <= (cmd_data.kind == CMD_RETRIGGER) ? '0 : cmd_data.module_index;
      bit_r      <= '0;
      pass_r     <= 1'b0;
      last_mod_r <= cmd_data.last_module;
      diff_r     <= levels_r[cmd_data.module_index] ^ cmd_data.sample_byte;
      byte_r     <= cmd_data.sample_byte;
    end else if (advance) begin
      bit_r <= bit_r + BIT_W'(1);
      if (retrig_r && bit_r == BIT_W'(BITS_PER_MODULE - 1)) begin
        if (mod_r == last_mod_r) begin
          mod_r  <= '0;
          pass_r <= 1'b1;
        end else begin
          mod_r <= mod_r + MOD_W'(1);
        end
      end
    end
    if (advance && hit) begin
      hold_pin_r   <= PIN_W'({mod_r, bit_r});
      hold_press_r <= hit_press;
    end
    if (push) begin
      out_r.input_number <= hold_pin_r;
      out_r.is_press     <= hold_press_r;
      out_r.last_of_run  <= push_last;
    end
  end

endmodule

### design/shift_input_change_events.sv
// Sample: taken in idle, the walk covers the 8 bits of its module; a flush state sends any
// held event as last of the run before the back end returns to idle for the next command.
// Retrigger: the walk covers each module in use in two passes (releases, then presses).
// Prime is taken without a walk; ignored items cost only the input transfer.
// The back end walks a bit per cycle unless the output stalls; a two-entry queue is ahead.
// Synchronous reset (rst_n low) clears levels, queue and outputs and sets the count to one.
module shift_input_change_events (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sice_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sice_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [sice_pkg::COUNT_W-1:0] cfg_wdata
);
  import sice_pkg::*;

  logic [COUNT_W-1:0] module_count_r;
  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd_data;

  // Module count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      module_count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      module_count_r <= cfg_wdata;
    end
  end

  sice_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .module_count(module_count_r),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd_data    (cmd_data)
  );

  sice_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data (cmd_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

### design/sice_checker.sv
module sice_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sice_pkg::out_item_t out_data
);
  import sice_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Reset empties the command queue, so input is taken at once.
  assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind shift_input_change_events sice_checker u_sice_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

### verif/tb.sv
module tb;
  import sice_pkg::*;

  // Operation code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CLK_PERIOD   = 20;
  localparam int SETTLE       = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SHOWN_ERRORS = 10;

  // Predicts the change events of the module chain and checks the event transfers.
  class event_scoreboard;
    logic [BITS_PER_MODULE-1:0] levels [MAX_MODULES];
    logic [COUNT_W-1:0] count_reg;
    out_item_t expected_events[$];
    int errors;
    int inputs_taken;
    int events_checked;
    int retriggers;
    int ignored;

    function new();
      foreach (levels[m]) levels[m] = '0;
      count_reg = COUNT_RESET;
      errors = 0;
      inputs_taken = 0;
      events_checked = 0;
      retriggers = 0;
      ignored = 0;
    endfunction

    function void write_count(logic [COUNT_W-1:0] value);
      count_reg = value;
    endfunction

    // A count of zero acts as one module, a count past the chain as the full chain.
    function int active_count();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_MODULES) return MAX_MODULES;
      return int'(count_reg);
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    // Works out the events that one accepted input transfer causes.
    function void note_input(in_item_t item);
      logic [PIN_W-1:0] pins[$];
      logic presses[$];
      out_item_t ev;
      int n;
      int mi;
      n = active_count();
      mi = int'(item.module_index);
      inputs_taken++;
      case (item.operation)
        OP_SAMPLE, OP_PRIME: begin
          if (mi >= n) begin
            ignored++;
          end else begin
            if (item.operation == OP_SAMPLE) begin
              for (int b = 0; b < BITS_PER_MODULE; b++) begin
                if (item.sample_byte[b] != levels[mi][b]) begin
                  pins.push_back(PIN_W'(mi * BITS_PER_MODULE + b));
                  presses.push_back(~item.sample_byte[b]);
                end
              end
            end
            levels[mi] = item.sample_byte;
          end
        end
        OP_RETRIGGER: begin
          // Releases for every high level first, then presses for every low level.
          retriggers++;
          for (int m = 0; m < n; m++) begin
            for (int b = 0; b < BITS_PER_MODULE; b++) begin
              if (levels[m][b]) begin
                pins.push_back(PIN_W'(m * BITS_PER_MODULE + b));
                presses.push_back(1'b0);
              end
            end
          end
          for (int m = 0; m < n; m++) begin
            for (int b = 0; b < BITS_PER_MODULE; b++) begin
              if (!levels[m][b]) begin
                pins.push_back(PIN_W'(m * BITS_PER_MODULE + b));
                presses.push_back(1'b1);
              end
            end
          end
        end
        default: begin
          ignored++;
        end
      endcase
      for (int i = 0; i < pins.size(); i++) begin
        ev.input_number = pins[i];
        ev.is_press = presses[i];
        ev.last_of_run = (i == pins.size() - 1);
        expected_events.push_back(ev);
      end
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= SHOWN_ERRORS) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Compares one event transfer with the oldest expected event.
    function void check_result(out_item_t got);
      out_item_t want;
      events_checked++;
      if (expected_events.size() == 0) begin
        note_error($sformatf("unexpected event: pin %0d press %0b last %0b",
                             got.input_number, got.is_press, got.last_of_run));
        return;
      end
      want = expected_events.pop_front();
      if (got.input_number !== want.input_number || got.is_press !== want.is_press ||
          got.last_of_run !== want.last_of_run) begin
        note_error($sformatf({"event %0d mismatch: expected pin %0d press %0b last %0b,",
                              " got pin %0d press %0b last %0b"}, events_checked,
                             want.input_number, want.is_press, want.last_of_run,
                             got.input_number, got.is_press, got.last_of_run));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;

  event_scoreboard sb;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  bit hold_off = 1'b0;
  int settings_used = 0;
  int holds_done = 0;

  shift_input_change_events dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Watch register writes and both channels at every rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_count(cfg_wdata);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_input(in_data);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off when asked for.
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
        holds_done++;
      end else if (receiver_idles && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic in_item_t mk(logic [1:0] op, logic [2:0] mi, logic [7:0] value);
    in_item_t it;
    it.operation = op;
    it.module_index = mi;
    it.sample_byte = value;
    return it;
  endfunction

  // Offers one input item, maybe after an idle burst, and waits for its transfer.
  task automatic offer(input in_item_t item);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_count(input logic [COUNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Waits for every expected event, then lets trailing silent work finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One setting of the module count followed by random traffic.
  task automatic run_random_phase(input logic [COUNT_W-1:0] count, input int quota,
                                  input bit pressure);
    in_item_t it;
    int useful;
    int n;
    int pick;
    bit saved_idles;
    saved_idles = sender_idles;
    write_count(count);
    if (pressure) begin
      sender_idles = 1'b0;
      hold_off = 1'b1;
    end
    useful = 0;
    while (useful < quota) begin
      n = sb.active_count();
      if ($urandom_range(0, 9) == 0) it.module_index = 3'($urandom_range(0, 7));
      else it.module_index = 3'($urandom_range(0, n - 1));
      pick = $urandom_range(0, 99);
      if (pick < 62) it.operation = OP_SAMPLE;
      else if (pick < 84) it.operation = OP_PRIME;
      else if (pick < 92) it.operation = OP_RETRIGGER;
      else it.operation = OP_UNUSED;
      // Bias samples toward no change and single-bit changes as well as random bytes.
      pick = $urandom_range(0, 9);
      if (pick < 2) it.sample_byte = sb.levels[it.module_index];
      else if (pick < 5)
        it.sample_byte = sb.levels[it.module_index] ^ (8'd1 << $urandom_range(0, 7));
      else it.sample_byte = 8'($urandom_range(0, 255));
      if (it.operation == OP_RETRIGGER ||
          (it.operation != OP_UNUSED && int'(it.module_index) < n)) useful++;
      offer(it);
    end
    drain();
    sender_idles = saved_idles;
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset count of one: all releases, no change, unused module, retrigger, bad code.
    offer(mk(OP_SAMPLE, 3'd0, 8'hFF));
    offer(mk(OP_SAMPLE, 3'd0, 8'hFF));
    offer(mk(OP_SAMPLE, 3'd1, 8'h0F));
    offer(mk(OP_RETRIGGER, 3'd0, 8'h00));
    offer(mk(OP_UNUSED, 3'd7, 8'hFF));
    drain();

    // Full chain: top module, all presses, a single press and a single release on the top bit of a byte.
    write_count(COUNT_W'(MAX_MODULES));
    offer(mk(OP_PRIME, 3'd7, 8'hA5));
    offer(mk(OP_SAMPLE, 3'd7, 8'h5A));
    offer(mk(OP_SAMPLE, 3'd0, 8'h00));
    offer(mk(OP_PRIME, 3'd3, 8'hFF));
    offer(mk(OP_SAMPLE, 3'd3, 8'h7F));
    offer(mk(OP_SAMPLE, 3'd5, 8'h80));
    offer(mk(OP_RETRIGGER, 3'd2, 8'h33));
    drain();

    // A count of zero behaves as a single module.
    write_count('0);
    offer(mk(OP_SAMPLE, 3'd2, 8'hFF));
    offer(mk(OP_PRIME, 3'd1, 8'hFF));
    offer(mk(OP_SAMPLE, 3'd0, 8'h81));
    offer(mk(OP_RETRIGGER, 3'd7, 8'hFF));
    drain();

    // A count above the chain length behaves as the full chain.
    write_count('1);
    offer(mk(OP_SAMPLE, 3'd7, 8'h00));
    offer(mk(OP_PRIME, 3'd4, 8'hFF));
    offer(mk(OP_RETRIGGER, 3'd0, 8'h00));
    offer(mk(OP_UNUSED, 3'd0, 8'h00));
    drain();

    run_random_phase(COUNT_W'(3), 14, 1'b0);
    run_random_phase(COUNT_W'(MAX_MODULES), 14, 1'b1);
    run_random_phase(COUNT_W'(2), 14, 1'b0);
    run_random_phase('1, 14, 1'b0);
    run_random_phase(COUNT_W'($urandom_range(0, 15)), 14, 1'b0);

    // Last stretch runs with no idling on either side.
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    run_random_phase(COUNT_W'(1), 14, 1'b0);

    $display("Run covered %0d input transfers (%0d retriggers, %0d ignored) and %0d events",
             sb.inputs_taken, sb.retriggers, sb.ignored, sb.events_checked);
    $display("over %0d module-count settings with %0d long receiver hold-off(s).",
             settings_used, holds_done);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Safety limit well above the slowest correct run.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d events still expected", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
